// File: rtl/ctt_pkg.sv
// ----------------------------------------------------------------------------
// ctt_pkg
// Shared types and constants of the configuration text tokenizer: token
// codes, the result record, and the bundle of results that one byte causes.
// ----------------------------------------------------------------------------
package ctt_pkg;

  // Width of the line and column counters.
  localparam int CoordBits = 16;
  localparam logic [CoordBits-1:0] CoordMax = '1;

  // Width of an integer token value.
  localparam int IntBits = 63;

  // One byte causes at most this many results.
  localparam int MaxResults = 3;
  localparam int ResIdxBits = $clog2(MaxResults);
  localparam int ResCntBits = $clog2(MaxResults + 1);

  // Depth of the queue between the scanner and the output sequencer.
  localparam int QueueDepth = 2;
  localparam int QPtrBits   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntBits   = $clog2(QueueDepth + 1);

  // Item kinds.
  localparam logic ItemToken = 1'b0;
  localparam logic ItemText  = 1'b1;

  // Token kinds.
  localparam logic [3:0] TokNewline  = 4'd0;
  localparam logic [3:0] TokField    = 4'd1;
  localparam logic [3:0] TokBool     = 4'd2;
  localparam logic [3:0] TokInt      = 4'd3;
  localparam logic [3:0] TokString   = 4'd4;
  localparam logic [3:0] TokEqual    = 4'd5;
  localparam logic [3:0] TokLBrace   = 4'd6;
  localparam logic [3:0] TokRBrace   = 4'd7;
  localparam logic [3:0] TokLBracket = 4'd8;
  localparam logic [3:0] TokRBracket = 4'd9;
  localparam logic [3:0] TokComma    = 4'd10;
  localparam logic [3:0] TokError    = 4'd11;

  // One result item, without its end-of-run flag.
  typedef struct packed {
    logic                 item_kind;
    logic [3:0]           token_kind;
    logic [7:0]           char_value;
    logic [IntBits-1:0]   integer_value;
    logic                 truth_value;
    logic [CoordBits-1:0] start_line;
    logic [CoordBits-1:0] start_column;
    logic [CoordBits-1:0] end_line;
    logic [CoordBits-1:0] end_column;
  } res_t;

  // All results of one input beat, in order.
  typedef struct packed {
    logic [ResCntBits-1:0]   count;
    res_t [MaxResults-1:0]   res;
  } bundle_t;

endpackage

// File: rtl/ctt_in_if.sv
// ----------------------------------------------------------------------------
// ctt_in_if
// Input channel of the tokenizer: one text byte per beat.
// ----------------------------------------------------------------------------
interface ctt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source(output valid, output text_byte, output end_of_text, input ready);
  modport sink(input valid, input text_byte, input end_of_text, output ready);
endinterface

// File: rtl/ctt_out_if.sv
// ----------------------------------------------------------------------------
// ctt_out_if
// Output channel of the tokenizer: one token or text character per beat.
// ----------------------------------------------------------------------------
interface ctt_out_if;
  import ctt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 item_kind;
  logic [3:0]           token_kind;
  logic [7:0]           char_value;
  logic [IntBits-1:0]   integer_value;
  logic                 truth_value;
  logic [CoordBits-1:0] start_line;
  logic [CoordBits-1:0] start_column;
  logic [CoordBits-1:0] end_line;
  logic [CoordBits-1:0] end_column;
  logic                 run_end;

  modport source(
    output valid, input ready,
    output item_kind, output token_kind, output char_value, output integer_value,
    output truth_value, output start_line, output start_column, output end_line,
    output end_column, output run_end
  );
  modport sink(
    input valid, output ready,
    input item_kind, input token_kind, input char_value, input integer_value,
    input truth_value, input start_line, input start_column, input end_line,
    input end_column, input run_end
  );
endinterface

// File: rtl/ctt_front.sv
// ----------------------------------------------------------------------------
// ctt_front
// Scanner: takes one byte per beat, tracks position, classifies the byte
// against the scan state and builds the bundle of results it causes.
// ----------------------------------------------------------------------------
module ctt_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  ctt_in_if.sink            in_ch,
  input  logic              full_i,
  output logic              push_o,
  output ctt_pkg::bundle_t  bundle_o
);
  import ctt_pkg::*;

  // Scan state codes.
  localparam logic [2:0] ModeIdle     = 3'd0;
  localparam logic [2:0] ModeIdent    = 3'd1;
  localparam logic [2:0] ModeNumber   = 3'd2;
  localparam logic [2:0] ModeStrFirst = 3'd3;
  localparam logic [2:0] ModeString   = 3'd4;
  localparam logic [2:0] ModeComment  = 3'd5;
  localparam logic [2:0] ModeHalt     = 3'd6;

  // Characters with a meaning of their own.
  localparam logic [7:0] ChLf      = 8'h0a;
  localparam logic [7:0] ChQuote   = 8'h22;
  localparam logic [7:0] ChHash    = 8'h23;
  localparam logic [7:0] ChEqual   = 8'h3d;
  localparam logic [7:0] ChLBrace  = 8'h7b;
  localparam logic [7:0] ChRBrace  = 8'h7d;
  localparam logic [7:0] ChLBrack  = 8'h5b;
  localparam logic [7:0] ChRBrack  = 8'h5d;
  localparam logic [7:0] ChComma   = 8'h2c;
  localparam logic [7:0] ChUnder   = 8'h5f;
  localparam logic [7:0] ChDash    = 8'h2d;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChLowT    = 8'h74;
  localparam logic [7:0] ChLowF    = 8'h66;

  // Keyword tracker codes: 1..4 walk "true", 5..9 walk "false".
  localparam logic [4:0] KwNone      = 5'd0;
  localparam logic [4:0] KwTrueFirst = 5'd1;
  localparam logic [4:0] KwTrueDone  = 5'd4;
  localparam logic [4:0] KwFalseFirst = 5'd5;
  localparam logic [4:0] KwFalseDone = 5'd9;

  logic [2:0]           mode_q, mode_d;
  logic [CoordBits-1:0] line_q, line_d;
  logic [CoordBits-1:0] col_q, col_d;
  logic [CoordBits-1:0] tsl_q, tsl_d;
  logic [CoordBits-1:0] tsc_q, tsc_d;
  logic [IntBits-1:0]   acc_q, acc_d;
  logic                 ovf_q, ovf_d;
  logic [4:0]           kw_q, kw_d;

  logic                 accept;
  logic [7:0]           c;
  logic [IntBits+3:0]   prod;
  bundle_t              bnd;

  // Builds one result record.
  function automatic res_t mk(logic item, logic [3:0] kind, logic [7:0] ch,
                              logic [IntBits-1:0] ival, logic truth,
                              logic [CoordBits-1:0] sl, logic [CoordBits-1:0] sc,
                              logic [CoordBits-1:0] el, logic [CoordBits-1:0] ec);
    res_t r;
    r.item_kind     = item;
    r.token_kind    = kind;
    r.char_value    = ch;
    r.integer_value = ival;
    r.truth_value   = truth;
    r.start_line    = sl;
    r.start_column  = sc;
    r.end_line      = el;
    r.end_column    = ec;
    return r;
  endfunction

  // Appends a result to a bundle; a full bundle stays as it is.
  function automatic bundle_t put(bundle_t b, res_t r);
    bundle_t o;
    o = b;
    if (o.count != ResCntBits'(MaxResults)) begin
      o.res[o.count[ResIdxBits-1:0]] = r;
      o.count = o.count + ResCntBits'(1);
    end
    return o;
  endfunction

  function automatic logic is_letter(logic [7:0] ch);
    return ch inside {[8'h41:8'h5a], [8'h61:8'h7a]};
  endfunction

  function automatic logic is_digit(logic [7:0] ch);
    return ch inside {[8'h30:8'h39]};
  endfunction

  // Next keyword tracker value after an identifier character.
  function automatic logic [4:0] kw_next(logic [4:0] p, logic [7:0] ch);
    logic [7:0] want;
    case (p)
      5'd1:    want = 8'h72;  // r
      5'd2:    want = 8'h75;  // u
      5'd3:    want = 8'h65;  // e
      5'd5:    want = 8'h61;  // a
      5'd6:    want = 8'h6c;  // l
      5'd7:    want = 8'h73;  // s
      5'd8:    want = 8'h65;  // e
      default: want = 8'h00;
    endcase
    if (want != 8'h00 && ch == want) begin
      return p + 5'd1;
    end
    return KwNone;
  endfunction

  // Token that closes an identifier.
  function automatic res_t ident_token(logic [4:0] p, logic [CoordBits-1:0] sl,
                                       logic [CoordBits-1:0] sc,
                                       logic [CoordBits-1:0] el,
                                       logic [CoordBits-1:0] ec);
    if (p == KwTrueDone) begin
      return mk(ItemToken, TokBool, 8'h00, '0, 1'b1, sl, sc, el, ec);
    end
    if (p == KwFalseDone) begin
      return mk(ItemToken, TokBool, 8'h00, '0, 1'b0, sl, sc, el, ec);
    end
    return mk(ItemToken, TokField, 8'h00, '0, 1'b0, sl, sc, el, ec);
  endfunction

  assign c           = in_ch.text_byte;
  assign in_ch.ready = !full_i;
  assign accept      = in_ch.valid && in_ch.ready;

  // Decimal step: acc * 10 + digit, widened so that overflow shows in the top bits.
  assign prod = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} +
                {(IntBits + 4)'(c - ChZero)};

  // Scan step: position update, per-state handling, fresh-byte handling, flush.
  always_comb begin
    logic                 do_idle;
    logic [3:0]           pkind;
    logic [CoordBits-1:0] cl;
    logic [CoordBits-1:0] cc;
    mode_d    = mode_q;
    line_d    = line_q;
    col_d     = col_q;
    tsl_d     = tsl_q;
    tsc_d     = tsc_q;
    acc_d     = acc_q;
    ovf_d     = ovf_q;
    kw_d      = kw_q;
    bnd       = '0;
    do_idle   = 1'b0;
    pkind     = TokError;
    cl        = line_q;
    cc        = col_q;

    if (mode_q != ModeHalt) begin
      // Position counters, saturating.
      if (c == ChLf) begin
        if (line_q != CoordMax) begin
          line_d = line_q + CoordBits'(1);
        end
        col_d = '0;
      end else if (col_q != CoordMax) begin
        col_d = col_q + CoordBits'(1);
      end
      cl = line_d;
      cc = col_d;

      // Handling that depends on the scan state.
      case (mode_q)
        ModeIdent: begin
          if (is_letter(c) || is_digit(c) || c == ChUnder || c == ChDash) begin
            kw_d = kw_next(kw_q, c);
            bnd  = put(bnd, mk(ItemText, TokField, c, '0, 1'b0, cl, cc, cl, cc));
          end else begin
            bnd     = put(bnd, ident_token(kw_q, tsl_q, tsc_q, line_q, col_q));
            do_idle = 1'b1;
          end
        end
        ModeNumber: begin
          if (is_digit(c)) begin
            if (!ovf_q) begin
              if (prod[IntBits+3:IntBits] != 4'd0) begin
                ovf_d = 1'b1;
              end else begin
                acc_d = prod[IntBits-1:0];
              end
            end
          end else if (ovf_q) begin
            bnd    = put(bnd, mk(ItemToken, TokError, 8'h00, '0, 1'b0,
                                 tsl_q, tsc_q, line_q, col_q));
            mode_d = ModeHalt;
          end else begin
            bnd     = put(bnd, mk(ItemToken, TokInt, 8'h00, acc_q, 1'b0,
                                  tsl_q, tsc_q, line_q, col_q));
            do_idle = 1'b1;
          end
        end
        ModeStrFirst, ModeString: begin
          if (mode_q == ModeStrFirst) begin
            tsl_d  = cl;
            tsc_d  = cc;
            mode_d = ModeString;
          end
          if (c == ChQuote) begin
            bnd    = put(bnd, mk(ItemToken, TokString, 8'h00, '0, 1'b0,
                                 tsl_d, tsc_d, cl, cc));
            mode_d = ModeIdle;
          end else begin
            bnd = put(bnd, mk(ItemText, TokString, c, '0, 1'b0, cl, cc, cl, cc));
          end
        end
        ModeComment: begin
          do_idle = (c == ChLf);
        end
        default: begin
          do_idle = 1'b1;
        end
      endcase

      // A byte seen fresh, outside any token.
      if (do_idle) begin
        mode_d = ModeIdle;
        case (c)
          ChEqual:  pkind = TokEqual;
          ChLBrace: pkind = TokLBrace;
          ChRBrace: pkind = TokRBrace;
          ChLBrack: pkind = TokLBracket;
          ChRBrack: pkind = TokRBracket;
          ChComma:  pkind = TokComma;
          default:  pkind = TokError;
        endcase
        if (c == ChLf) begin
          bnd = put(bnd, mk(ItemToken, TokNewline, c, '0, 1'b0, cl, cc, cl, cc));
        end else if (c inside {8'h09, 8'h0b, 8'h0c, 8'h0d, 8'h20}) begin
          mode_d = ModeIdle;
        end else if (is_letter(c)) begin
          mode_d = ModeIdent;
          tsl_d  = cl;
          tsc_d  = cc;
          kw_d   = (c == ChLowT) ? KwTrueFirst : ((c == ChLowF) ? KwFalseFirst : KwNone);
          bnd    = put(bnd, mk(ItemText, TokField, c, '0, 1'b0, cl, cc, cl, cc));
        end else if (is_digit(c)) begin
          mode_d = ModeNumber;
          tsl_d  = cl;
          tsc_d  = cc;
          acc_d  = IntBits'(c - ChZero);
          ovf_d  = 1'b0;
        end else if (c == ChQuote) begin
          mode_d = ModeStrFirst;
        end else if (c == ChHash) begin
          mode_d = ModeComment;
        end else begin
          bnd = put(bnd, mk(ItemToken, pkind, c, '0, 1'b0, cl, cc, cl, cc));
          if (pkind == TokError) begin
            mode_d = ModeHalt;
          end
        end
      end

      // End of text: close the pending token and start a new text.
      if (in_ch.end_of_text && mode_d != ModeHalt) begin
        case (mode_d)
          ModeIdent: begin
            bnd = put(bnd, ident_token(kw_d, tsl_d, tsc_d, cl, cc));
          end
          ModeNumber: begin
            if (ovf_d) begin
              bnd    = put(bnd, mk(ItemToken, TokError, 8'h00, '0, 1'b0,
                                   tsl_d, tsc_d, cl, cc));
              mode_d = ModeHalt;
            end else begin
              bnd = put(bnd, mk(ItemToken, TokInt, 8'h00, acc_d, 1'b0,
                                tsl_d, tsc_d, cl, cc));
            end
          end
          ModeStrFirst: begin
            bnd    = put(bnd, mk(ItemToken, TokError, 8'h00, '0, 1'b0, cl, cc, cl, cc));
            mode_d = ModeHalt;
          end
          ModeString: begin
            bnd    = put(bnd, mk(ItemToken, TokError, 8'h00, '0, 1'b0,
                                 tsl_d, tsc_d, cl, cc));
            mode_d = ModeHalt;
          end
          default: begin
            mode_d = mode_d;
          end
        endcase
        if (mode_d != ModeHalt) begin
          mode_d = ModeIdle;
          line_d = '0;
          col_d  = '0;
          acc_d  = '0;
          ovf_d  = 1'b0;
          kw_d   = KwNone;
        end
      end
    end
  end

  assign push_o   = accept && (bnd.count != ResCntBits'(0));
  assign bundle_o = bnd;

  // Scan state advances on every accepted beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      line_q <= '0;
      col_q  <= '0;
      tsl_q  <= '0;
      tsc_q  <= '0;
      acc_q  <= '0;
      ovf_q  <= 1'b0;
      kw_q   <= KwNone;
    end else if (accept) begin
      mode_q <= mode_d;
      line_q <= line_d;
      col_q  <= col_d;
      tsl_q  <= tsl_d;
      tsc_q  <= tsc_d;
      acc_q  <= acc_d;
      ovf_q  <= ovf_d;
      kw_q   <= kw_d;
    end
  end

endmodule

// File: rtl/ctt_queue.sv
// ----------------------------------------------------------------------------
// ctt_queue
// Short first-in first-out queue of result bundles between the scanner and
// the output sequencer.
// ----------------------------------------------------------------------------
module ctt_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ctt_pkg::bundle_t  bundle_i,
  output logic              full_o,
  output logic              head_valid_o,
  output ctt_pkg::bundle_t  head_o,
  input  logic              pop_i
);
  import ctt_pkg::*;

  bundle_t [QueueDepth-1:0] mem_q;
  logic [QPtrBits-1:0]      wr_ptr_q, rd_ptr_q;
  logic [QCntBits-1:0]      count_q;

  assign full_o       = (count_q == QCntBits'(QueueDepth));
  assign head_valid_o = (count_q != QCntBits'(0));
  assign head_o       = mem_q[rd_ptr_q];

  function automatic logic [QPtrBits-1:0] ptr_inc(logic [QPtrBits-1:0] p);
    if (p == QPtrBits'(QueueDepth - 1)) begin
      return '0;
    end
    return p + QPtrBits'(1);
  endfunction

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= bundle_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QCntBits'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QCntBits'(1);
      end
    end
  end

endmodule

// File: rtl/ctt_back.sv
// ----------------------------------------------------------------------------
// ctt_back
// Output sequencer: sends the results of the head bundle one beat at a time
// and marks the last one of each bundle.
// ----------------------------------------------------------------------------
module ctt_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  ctt_pkg::bundle_t  head_i,
  output logic              pop_o,
  ctt_out_if.source         out_ch
);
  import ctt_pkg::*;

  logic [ResIdxBits-1:0] idx_q, idx_d;
  logic                  last;
  logic                  fire;
  res_t                  cur;

  assign cur  = head_i.res[idx_q];
  assign last = ((ResCntBits'(idx_q) + ResCntBits'(1)) == head_i.count);
  assign fire = out_ch.valid && out_ch.ready;

  // Drive the channel from the selected result.
  assign out_ch.valid         = head_valid_i;
  assign out_ch.item_kind     = cur.item_kind;
  assign out_ch.token_kind    = cur.token_kind;
  assign out_ch.char_value    = cur.char_value;
  assign out_ch.integer_value = cur.integer_value;
  assign out_ch.truth_value   = cur.truth_value;
  assign out_ch.start_line    = cur.start_line;
  assign out_ch.start_column  = cur.start_column;
  assign out_ch.end_line      = cur.end_line;
  assign out_ch.end_column    = cur.end_column;
  assign out_ch.run_end       = last;

  assign pop_o = fire && last;

  // Step through the bundle; the last beat releases it.
  always_comb begin
    idx_d = idx_q;
    if (fire) begin
      idx_d = last ? '0 : idx_q + ResIdxBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

// File: rtl/config_text_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// config_text_tokenizer_unit
// Streaming tokenizer for a small configuration text format: one text byte
// in, tokens and identifier or string characters out.
// ----------------------------------------------------------------------------
//
//   Channel   Port     Dir  Beat
//   text      text_i   in   text_byte, end_of_text
//   token     token_o  out  item_kind, token_kind, char_value, integer_value,
//                           truth_value, start/end line and column, run_end
//
// The scanner takes one byte per cycle; a byte is fully classified in the
// cycle it is accepted, and its up to three results go into a two-entry queue.
// The output sequencer sends one result per cycle, so the sustained rate is
// one byte per cycle while bytes cause at most one result each on average.
// Reset clears the scan state and empties the queue; there is no clearing pass.
// The input stalls only when the queue is full; the output stalls independently.
//
module config_text_tokenizer_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  ctt_in_if.sink     text_i,
  ctt_out_if.source  token_o
);
  import ctt_pkg::*;

  logic    push;
  logic    full;
  logic    head_valid;
  logic    pop;
  bundle_t push_bundle;
  bundle_t head;

  // Scanner.
  ctt_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch    (text_i),
    .full_i   (full),
    .push_o   (push),
    .bundle_o (push_bundle)
  );

  // Queue of result bundles.
  ctt_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .bundle_i     (push_bundle),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  // Output sequencer.
  ctt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_ch       (token_o)
  );

`ifndef SYNTHESIS
  // The scanner never writes into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push && full))
    else $error("bundle pushed into a full queue");

  // Every queued bundle carries at least one result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid |-> (head.count != ResCntBits'(0)))
    else $error("empty bundle at the head of the queue");

  // A bundle is released only while one is present.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> head_valid)
    else $error("queue popped while empty");

  // An empty queue stays empty unless the scanner pushes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!head_valid && !push) |=> !head_valid)
    else $error("queue became non-empty without a push");
`endif

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the configuration text tokenizer. A short table of
// hand-picked bytes opens the run, then random phrases of well-formed text,
// and a final error that halts the block. An in-bench token predictor works
// out every result beat, and the output stream is checked against it in order.
// ----------------------------------------------------------------------------
module tb;
  import ctt_pkg::*;

  localparam int ClkPeriod      = 4;
  localparam int ResetCycles    = 5;
  localparam int RandomItems    = 400;
  localparam int HoldOffCycles  = 400;
  localparam int DrainCycles    = 16;
  localparam int MaxReports     = 30;
  localparam int RunLimitCycles = 200_000;
  localparam logic [63:0] IntMax = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [7:0] StallPattern = 8'b1101_0111;

  typedef logic [CoordBits-1:0] coord_t;

  // Scanner phases of the predictor.
  typedef enum logic [2:0] {
    ScanIdle, ScanIdent, ScanNumber, ScanQuote, ScanString, ScanComment, ScanHalt
  } scan_mode_e;

  // One result beat as it should appear on the token channel.
  typedef struct packed {
    res_t res;
    logic run_end;
  } token_beat_t;

  // One row of the opening table: a byte and, where obvious, its token.
  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
    logic       typed;
    res_t       res;
  } text_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ctt_in_if  text_if ();
  ctt_out_if tok_if ();

  config_text_tokenizer_unit uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .text_i  (text_if),
    .token_o (tok_if)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Predictor state.
  scan_mode_e  tok_mode     = ScanIdle;
  coord_t      line_now     = '0;
  coord_t      col_now      = '0;
  coord_t      tok_line     = '0;
  coord_t      tok_col      = '0;
  logic [63:0] num_value    = '0;
  logic        num_overflow = 1'b0;
  logic [39:0] word_buf     = '0;
  int          word_len     = 0;

  res_t        step_tokens[$];
  token_beat_t expected_tokens[$];

  int   mismatch_count = 0;
  int   token_beats    = 0;
  int   burst_left     = 0;
  bit   hold_off_req   = 1'b0;
  int   hold_left      = 0;
  int   pattern_left   = 0;
  int   stall_mode     = 0;
  logic [2:0] stall_phase = '0;

  string ident_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_-";
  string space_chars = " \t\r\013\014";
  string punct_chars = "={}[],";
  string noise_chars = "={}[], \t\rab09#Zz\n";
  string bad_chars   = "!@$%&()*./;:<>?\\^`|~+'-_";
  string near_words[10] = '{"true", "false", "tru", "fals", "truee", "falsex", "t", "f",
                            "True", "xtrue"};

  // --------------------------------------------------------------------------
  // Token predictor
  // --------------------------------------------------------------------------

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_ident_char(logic [7:0] c);
    return is_letter(c) || is_digit(c) || c == "_" || c == "-";
  endfunction

  function automatic void add_token(logic item, logic [3:0] kind, logic [7:0] ch,
                                    logic [IntBits-1:0] ival, logic truth,
                                    coord_t sl, coord_t sc, coord_t el, coord_t ec);
    res_t r;
    r.item_kind     = item;
    r.token_kind    = kind;
    r.char_value    = ch;
    r.integer_value = ival;
    r.truth_value   = truth;
    r.start_line    = sl;
    r.start_column  = sc;
    r.end_line      = el;
    r.end_column    = ec;
    step_tokens.push_back(r);
  endfunction

  // Keep the first five characters of an identifier for the keyword check.
  function automatic void grow_word(logic [7:0] c);
    if (word_len < 5) word_buf = {word_buf[31:0], c};
    if (word_len < 6) word_len++;
  endfunction

  // Only an exact "true" or "false" is a bool.
  function automatic void close_ident(coord_t el, coord_t ec);
    if (word_len == 4 && word_buf[31:0] == "true")
      add_token(ItemToken, TokBool, 8'h00, '0, 1'b1, tok_line, tok_col, el, ec);
    else if (word_len == 5 && word_buf == "false")
      add_token(ItemToken, TokBool, 8'h00, '0, 1'b0, tok_line, tok_col, el, ec);
    else
      add_token(ItemToken, TokField, 8'h00, '0, 1'b0, tok_line, tok_col, el, ec);
  endfunction

  // Returns 0 when the number overflowed and the scanner halted.
  function automatic bit close_number(coord_t el, coord_t ec);
    if (num_overflow) begin
      add_token(ItemToken, TokError, 8'h00, '0, 1'b0, tok_line, tok_col, el, ec);
      tok_mode = ScanHalt;
      return 1'b0;
    end
    add_token(ItemToken, TokInt, 8'h00, num_value[IntBits-1:0], 1'b0, tok_line, tok_col,
              el, ec);
    return 1'b1;
  endfunction

  function automatic void add_digit(logic [7:0] c);
    logic [63:0] d;
    d = {56'd0, c} - 64'd48;
    if (num_overflow) return;
    if (num_value > (IntMax - d) / 64'd10) num_overflow = 1'b1;
    else num_value = num_value * 64'd10 + d;
  endfunction

  // Handle a byte seen while no token is open.
  function automatic void start_fresh(logic [7:0] c, coord_t ln, coord_t col);
    logic [3:0] kind;
    tok_mode = ScanIdle;
    if (c == "\n") begin
      add_token(ItemToken, TokNewline, c, '0, 1'b0, ln, col, ln, col);
    end else if (c == " " || c == "\t" || c == "\r" || c == 8'h0B || c == 8'h0C) begin
      // White space is skipped.
    end else if (is_letter(c)) begin
      tok_mode = ScanIdent;
      tok_line = ln;
      tok_col  = col;
      word_len = 0;
      grow_word(c);
      add_token(ItemText, TokField, c, '0, 1'b0, ln, col, ln, col);
    end else if (is_digit(c)) begin
      tok_mode     = ScanNumber;
      tok_line     = ln;
      tok_col      = col;
      num_value    = '0;
      num_overflow = 1'b0;
      add_digit(c);
    end else if (c == "\"") begin
      tok_mode = ScanQuote;
    end else if (c == "#") begin
      tok_mode = ScanComment;
    end else begin
      case (c)
        "=":     kind = TokEqual;
        "{":     kind = TokLBrace;
        "}":     kind = TokRBrace;
        "[":     kind = TokLBracket;
        "]":     kind = TokRBracket;
        ",":     kind = TokComma;
        default: kind = TokError;
      endcase
      add_token(ItemToken, kind, c, '0, 1'b0, ln, col, ln, col);
      if (kind == TokError) tok_mode = ScanHalt;
    end
  endfunction

  // Work out every result of one accepted byte into step_tokens.
  function automatic void predict_tokens(logic [7:0] c, logic eot);
    coord_t prev_line;
    coord_t prev_col;
    step_tokens.delete();
    if (tok_mode == ScanHalt) return;

    // Advance the position over this byte, saturating.
    prev_line = line_now;
    prev_col  = col_now;
    if (c == "\n") begin
      if (line_now != CoordMax) line_now++;
      col_now = '0;
    end else if (col_now != CoordMax) begin
      col_now++;
    end

    case (tok_mode)
      ScanIdent: begin
        if (is_ident_char(c)) begin
          grow_word(c);
          add_token(ItemText, TokField, c, '0, 1'b0, line_now, col_now, line_now, col_now);
        end else begin
          close_ident(prev_line, prev_col);
          start_fresh(c, line_now, col_now);
        end
      end
      ScanNumber: begin
        if (is_digit(c)) add_digit(c);
        else if (close_number(prev_line, prev_col)) start_fresh(c, line_now, col_now);
      end
      ScanQuote, ScanString: begin
        if (tok_mode == ScanQuote) begin
          tok_line = line_now;
          tok_col  = col_now;
          tok_mode = ScanString;
        end
        if (c == "\"") begin
          add_token(ItemToken, TokString, 8'h00, '0, 1'b0, tok_line, tok_col, line_now,
                    col_now);
          tok_mode = ScanIdle;
        end else begin
          add_token(ItemText, TokString, c, '0, 1'b0, line_now, col_now, line_now, col_now);
        end
      end
      ScanComment: begin
        if (c == "\n") start_fresh(c, line_now, col_now);
      end
      default: start_fresh(c, line_now, col_now);
    endcase

    // End of text flushes the open token and starts a new text.
    if (eot && tok_mode != ScanHalt) begin
      case (tok_mode)
        ScanIdent:  close_ident(line_now, col_now);
        ScanNumber: void'(close_number(line_now, col_now));
        ScanQuote: begin
          add_token(ItemToken, TokError, 8'h00, '0, 1'b0, line_now, col_now, line_now,
                    col_now);
          tok_mode = ScanHalt;
        end
        ScanString: begin
          add_token(ItemToken, TokError, 8'h00, '0, 1'b0, tok_line, tok_col, line_now,
                    col_now);
          tok_mode = ScanHalt;
        end
        default: ;
      endcase
      if (tok_mode != ScanHalt) begin
        tok_mode     = ScanIdle;
        line_now     = '0;
        col_now      = '0;
        num_value    = '0;
        num_overflow = 1'b0;
        word_len     = 0;
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Text sender
  // --------------------------------------------------------------------------

  // Offer one byte in bursts with random gaps, then record what it must cause.
  task automatic send_beat(input logic [7:0] ch, input logic eot, input bit use_typed = 1'b0,
                           input res_t typed_res = '0);
    int gap;
    token_beat_t beat;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        text_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 20);
    end
    burst_left--;
    text_if.valid       <= 1'b1;
    text_if.text_byte   <= ch;
    text_if.end_of_text <= eot;
    do @(posedge clk_i); while (!text_if.ready);

    predict_tokens(ch, eot);
    if (use_typed) step_tokens = '{typed_res};
    foreach (step_tokens[i]) begin
      beat.res     = step_tokens[i];
      beat.run_end = (i == step_tokens.size() - 1);
      expected_tokens.push_back(beat);
    end
  endtask

  // Stop offering and wait until every predicted beat has been seen.
  task automatic drain_results();
    text_if.valid <= 1'b0;
    do @(posedge clk_i); while (expected_tokens.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Token receiver and checker
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    if (mismatch_count <= MaxReports)
      $display("MISMATCH beat %0d %s: got 'h%0h, expected 'h%0h", token_beats, what, got,
               want);
  endtask

  task automatic compare_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
    if (got !== want) report_mismatch(name, got, want);
  endtask

  task automatic check_token_beat();
    token_beat_t want;
    token_beats++;
    if (expected_tokens.size() == 0) begin
      report_mismatch("beat with nothing expected", {60'd0, tok_if.token_kind}, 64'd0);
      return;
    end
    want = expected_tokens.pop_front();
    compare_field("item_kind", 64'(tok_if.item_kind), 64'(want.res.item_kind));
    compare_field("token_kind", 64'(tok_if.token_kind), 64'(want.res.token_kind));
    compare_field("char_value", 64'(tok_if.char_value), 64'(want.res.char_value));
    compare_field("integer_value", 64'(tok_if.integer_value),
                  64'(want.res.integer_value));
    compare_field("truth_value", 64'(tok_if.truth_value), 64'(want.res.truth_value));
    compare_field("start_line", 64'(tok_if.start_line), 64'(want.res.start_line));
    compare_field("start_column", 64'(tok_if.start_column), 64'(want.res.start_column));
    compare_field("end_line", 64'(tok_if.end_line), 64'(want.res.end_line));
    compare_field("end_column", 64'(tok_if.end_column), 64'(want.res.end_column));
    compare_field("run_end", 64'(tok_if.run_end), 64'(want.run_end));
  endtask

  initial tok_if.ready = 1'b0;

  // Check each accepted beat, then pick the next ready level: a long hold-off
  // on request, otherwise stretches of full rate, a fixed pattern or coin flips.
  always @(posedge clk_i) begin
    if (rst_ni && tok_if.valid && tok_if.ready) check_token_beat();
    if (hold_off_req) begin
      hold_off_req = 1'b0;
      hold_left    = HoldOffCycles;
    end
    if (hold_left != 0) begin
      hold_left--;
      tok_if.ready <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        stall_mode   = $urandom_range(0, 2);
        pattern_left = $urandom_range(8, 64);
      end
      pattern_left--;
      stall_phase++;
      case (stall_mode)
        0:       tok_if.ready <= 1'b1;
        1:       tok_if.ready <= StallPattern[stall_phase];
        default: tok_if.ready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  function automatic text_row_t free_row(logic [7:0] ch, logic eot);
    text_row_t r;
    r     = '0;
    r.ch  = ch;
    r.eot = eot;
    return r;
  endfunction

  // A one-character token whose position is plain to see.
  function automatic text_row_t sure_row(logic [7:0] ch, logic [3:0] kind, coord_t ln,
                                         coord_t col);
    text_row_t r;
    r                  = '0;
    r.ch               = ch;
    r.typed            = 1'b1;
    r.res.item_kind    = ItemToken;
    r.res.token_kind   = kind;
    r.res.char_value   = ch;
    r.res.start_line   = ln;
    r.res.start_column = col;
    r.res.end_line     = ln;
    r.res.end_column   = col;
    return r;
  endfunction

  initial begin
    text_row_t  directed_rows[$];
    logic [7:0] phrase[$];
    logic [7:0] c;
    string      word;
    int         pick;
    int         random_items;
    bit         hold_sent;
    bit         eot_here;

    text_if.valid       = 1'b0;
    text_if.text_byte   = 8'h00;
    text_if.end_of_text = 1'b0;
    rst_ni              = 1'b0;
    random_items        = 0;
    hold_sent           = 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Opening table: every punctuation, newline, both keywords, a string with
    // the lowest and highest byte, a comment, and a flush on a lone digit.
    directed_rows = '{
      sure_row("=", TokEqual, 0, 1),
      sure_row("{", TokLBrace, 0, 2),
      sure_row("}", TokRBrace, 0, 3),
      sure_row("[", TokLBracket, 0, 4),
      sure_row("]", TokRBracket, 0, 5),
      sure_row(",", TokComma, 0, 6),
      sure_row("\n", TokNewline, 1, 0),
      free_row("t", 1'b0), free_row("r", 1'b0), free_row("u", 1'b0),
      free_row("e", 1'b0), free_row(" ", 1'b0),
      free_row("f", 1'b0), free_row("a", 1'b0), free_row("l", 1'b0),
      free_row("s", 1'b0), free_row("e", 1'b0), free_row("=", 1'b0),
      free_row("\"", 1'b0), free_row(8'h00, 1'b0), free_row(8'hFF, 1'b0),
      free_row("\"", 1'b0),
      free_row("#", 1'b0), free_row("x", 1'b0), free_row("\n", 1'b0),
      free_row("7", 1'b1)
    };
    foreach (directed_rows[i])
      send_beat(directed_rows[i].ch, directed_rows[i].eot, directed_rows[i].typed,
                directed_rows[i].res);
    drain_results();

    // Random phrases of well-formed text, with some noise in between.
    while (random_items < RandomItems) begin
      phrase.delete();
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
        // Identifier, sometimes a keyword or a near miss.
        if ($urandom_range(0, 4) == 0) begin
          word = near_words[$urandom_range(0, 9)];
          for (int k = 0; k < word.len(); k++) phrase.push_back(word[k]);
        end else begin
          phrase.push_back(ident_chars[$urandom_range(0, 51)]);
          repeat ($urandom_range(0, 7)) phrase.push_back(ident_chars[$urandom_range(0, 63)]);
        end
      end else if (pick < 40) begin
        // Integer, now and then the largest one that fits.
        if ($urandom_range(0, 9) == 0) begin
          word = "9223372036854775807";
          for (int k = 0; k < word.len(); k++) phrase.push_back(word[k]);
        end else begin
          repeat ($urandom_range(1, 18)) phrase.push_back(ident_chars[$urandom_range(52, 61)]);
        end
      end else if (pick < 55) begin
        // String with any bytes but the quote, newlines included; may be empty.
        phrase.push_back("\"");
        repeat ($urandom_range(0, 6)) begin
          if ($urandom_range(0, 6) == 0) c = "\n";
          else do c = 8'($urandom_range(0, 255)); while (c == "\"");
          phrase.push_back(c);
        end
        phrase.push_back("\"");
      end else if (pick < 72) begin
        phrase.push_back(punct_chars[$urandom_range(0, 5)]);
      end else if (pick < 82) begin
        phrase.push_back("\n");
      end else if (pick < 88) begin
        // Comment with arbitrary bytes up to the newline.
        phrase.push_back("#");
        repeat ($urandom_range(0, 5)) begin
          do c = 8'($urandom_range(0, 255)); while (c == "\n");
          phrase.push_back(c);
        end
        phrase.push_back("\n");
      end else if (pick < 93) begin
        repeat ($urandom_range(1, 4)) phrase.push_back(space_chars[$urandom_range(0, 4)]);
      end else begin
        repeat ($urandom_range(1, 6))
          phrase.push_back(noise_chars[$urandom_range(0, noise_chars.len() - 1)]);
      end
      if ($urandom_range(0, 1) == 1) phrase.push_back(space_chars[$urandom_range(0, 4)]);

      // Close a dangling comment, and keep digits from growing an open number.
      if (tok_mode == ScanComment) phrase.push_front("\n");
      else if (tok_mode == ScanNumber && is_digit(phrase[0])) phrase.push_front(" ");

      eot_here = ($urandom_range(0, 11) == 0);
      foreach (phrase[k]) send_beat(phrase[k], eot_here && k == phrase.size() - 1);
      random_items += phrase.size();

      // Halfway through, the receiver holds off so the block backs up.
      if (!hold_sent && random_items >= RandomItems / 2) begin
        hold_off_req = 1'b1;
        hold_sent    = 1'b1;
      end
    end

    // One error to finish with; the block halts and ignores the rest.
    phrase.delete();
    phrase.push_back("\n");
    case ($urandom_range(0, 3))
      0: begin
        if ($urandom_range(0, 1) == 1) c = bad_chars[$urandom_range(0, bad_chars.len() - 1)];
        else if ($urandom_range(0, 1) == 1) c = 8'h00;
        else c = 8'($urandom_range(127, 255));
        phrase.push_back(c);
        eot_here = 1'($urandom_range(0, 1));
      end
      1: begin
        word = "9223372036854775808";
        for (int k = 0; k < word.len(); k++) phrase.push_back(word[k]);
        repeat ($urandom_range(0, 3)) phrase.push_back(ident_chars[$urandom_range(52, 61)]);
        eot_here = 1'($urandom_range(0, 1));
        if (!eot_here) phrase.push_back(" ");
      end
      2: begin
        phrase.push_back("\"");
        repeat ($urandom_range(1, 4)) begin
          do c = 8'($urandom_range(0, 255)); while (c == "\"");
          phrase.push_back(c);
        end
        eot_here = 1'b1;
      end
      default: begin
        phrase.push_back("\"");
        eot_here = 1'b1;
      end
    endcase
    foreach (phrase[k]) send_beat(phrase[k], eot_here && k == phrase.size() - 1);
    repeat (3) send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

    // Wait for the last beats, then let the block settle.
    drain_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_tokens.size() != 0)
      report_mismatch("beats never delivered", 64'(expected_tokens.size()), 64'd0);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Hard stop in case the handshake hangs.
  initial begin
    #(RunLimitCycles * ClkPeriod);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: sim.f
rtl/ctt_pkg.sv
rtl/ctt_in_if.sv
rtl/ctt_out_if.sv
rtl/ctt_front.sv
rtl/ctt_queue.sv
rtl/ctt_back.sv
rtl/config_text_tokenizer_unit.sv
dv/tb.sv
